FILE: design/piecewise_linear_profile_lookup_macros.svh
// Assertion helpers shared by the profile lookup modules.
`ifndef PIECEWISE_LINEAR_PROFILE_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_PROFILE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PLPL_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PLPL_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/plpl_pkg.sv
package plpl_pkg;

    typedef logic signed [63:0] t_w64;

    localparam int DW        = 64;
    localparam int CW        = $clog2(DW);
    localparam int REC_W     = 32;
    localparam int REC_FIELDS = 5;

    localparam t_w64 SAT_LIM = 64'sh4000_0000_0000_0000;
    localparam t_w64 MAX32   = 64'sd2147483647;
    localparam t_w64 MIN32   = -64'sd2147483648;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        MODE_POINT  = 2'd0,
        MODE_SCALE  = 2'd1,
        MODE_OFFSET = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [5:0]         point_index;
        logic signed [31:0] point_dist;
        logic signed [31:0] point_z_left;
        logic signed [31:0] point_z_right;
        logic signed [31:0] point_bank_left;
        logic signed [31:0] point_bank_right;
        logic signed [31:0] query_distance;
        logic signed [31:0] lateral_offset;
    } t_in;

    typedef struct packed {
        logic signed [31:0] offset_z;
        logic signed [31:0] banking;
        logic               applied;
    } t_out;

    typedef enum logic {
        SEQ_DIV = 1'b0,
        SEQ_MUL = 1'b1
    } t_seq_op;

    typedef struct packed {
        logic    start;
        t_seq_op op;
    } t_seq_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_sts;

    function automatic logic signed [31:0] sat32(t_w64 v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7fff_ffff;
        end else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] zero_span(t_w64 y0, t_w64 dy, t_w64 dx);
        logic signed [31:0] r;
        if (dy == 64'sd0 || dx == 64'sd0) begin
            r = sat32(y0);
        end else if (dy[63] != dx[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

FILE: design/plpl_ram.sv
module plpl_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/plpl_seq.sv
`include "piecewise_linear_profile_lookup_macros.svh"

module plpl_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  plpl_pkg::t_seq_cmd i_cmd,
    input  plpl_pkg::t_w64   i_a,
    input  plpl_pkg::t_w64   i_b,
    output plpl_pkg::t_seq_sts o_sts,
    output plpl_pkg::t_w64   o_res,
    output plpl_pkg::t_w64   o_rem
);

    logic                    r_busy;
    logic                    r_done;
    plpl_pkg::t_seq_op       r_op;
    logic [plpl_pkg::CW-1:0] r_cnt;
    logic [64:0]             r_acc;
    logic [63:0]             r_sh;
    logic [63:0]             r_ub;
    logic                    r_neg;
    logic                    r_rneg;

    logic [63:0] ua;
    logic [63:0] ub;
    logic [64:0] trial;
    logic [64:0] msum;
    logic [64:0] n_acc;
    logic        qbit;

    always_comb begin
        ua    = i_a[63] ? 64'(-i_a) : 64'(i_a);
        ub    = i_b[63] ? 64'(-i_b) : 64'(i_b);
        trial = {r_acc[63:0], r_sh[63]};
        msum  = {r_acc[63:0], 1'b0} + (r_sh[63] ? {1'b0, r_ub} : 65'd0);
        qbit  = 1'b0;
        if (r_op == plpl_pkg::SEQ_DIV) begin
            if (trial >= {1'b0, r_ub}) begin
                n_acc = trial - {1'b0, r_ub};
                qbit  = 1'b1;
            end else begin
                n_acc = trial;
            end
        end else begin
            n_acc = (msum > 65'(plpl_pkg::SAT_LIM)) ? 65'(plpl_pkg::SAT_LIM) : msum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= plpl_pkg::SEQ_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= '1;
                r_acc  <= '0;
                r_neg  <= i_a[63] ^ i_b[63];
                r_rneg <= i_a[63];
                if (i_cmd.op == plpl_pkg::SEQ_DIV) begin
                    r_sh <= ua;
                    r_ub <= ub;
                end else begin
                    r_sh <= ub;
                    r_ub <= ua;
                end
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_sh  <= {r_sh[62:0], qbit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_op == plpl_pkg::SEQ_MUL) begin
            o_res = r_neg ? -$signed(r_acc[63:0]) : $signed(r_acc[63:0]);
        end else begin
            o_res = r_neg ? -$signed(r_sh) : $signed(r_sh);
        end
        o_rem      = r_rneg ? -$signed(r_acc[63:0]) : $signed(r_acc[63:0]);
        o_sts.busy = r_busy;
        o_sts.done = r_done;
    end

    `PLPL_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_cmd.start, !r_busy, "start while busy")
    `PLPL_ASSERT_NEXT(a_done_after, i_clk, i_rst_n, r_busy && r_cnt == '0, r_done && !r_busy, "missed done")
    `PLPL_ASSERT_IMPL(a_done_pulse, i_clk, i_rst_n, r_done, !r_busy, "done while busy")

endmodule

FILE: design/piecewise_linear_profile_lookup.sv
// channel   dir  handshake                     payload
// in        in   i_in_valid / o_in_stall       i_in_data  (plpl_pkg::t_in)
// out       out  o_out_valid / i_out_stall     o_out_data (plpl_pkg::t_out)
// cfg       in   psel/penable/pwrite/pready    paddr, pwdata, prdata
// A load leaves the input free for the next item; a query holds the input from accept
// until its result is registered, limited by the shared one-bit-per-cycle 64-step
// divide/multiply unit (wrap remainder, interpolation quotient, two products) and one profile
// memory read port; a disabled profile or an out-of-range query ends early.
// Synchronous active-low reset clears control (repeat resets to 1), scales to one, offsets; profile memory holds.
// o_in_stall is high while a query runs; a result waits in the output register.
`include "piecewise_linear_profile_lookup_macros.svh"

module piecewise_linear_profile_lookup #(
    parameter int PROFILE_POINTS = 64,
    parameter int FRAC_BITS      = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  plpl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output plpl_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW  = $clog2(PROFILE_POINTS);
    localparam int RW  = plpl_pkg::REC_W * plpl_pkg::REC_FIELDS;
    localparam int XW  = 64 + FRAC_BITS + 1;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_F0_RD, S_F0_MUL, S_F0_GET, S_FL_RD, S_FL_MUL, S_FL_GET,
        S_CHECK, S_REM, S_SRCH, S_S_RD, S_S_MUL, S_S_CMP,
        S_P_RD, S_P_MUL, S_P_GET, S_T, S_TDIV, S_MZ_GO, S_MZ, S_MB_GO, S_MB, S_FIN
    } t_state;

    t_state             r_state;
    logic               r_enable;
    logic               r_repeat;
    logic [6:0]         r_point_count;
    logic signed [31:0] r_scale [plpl_pkg::REC_FIELDS];
    logic signed [31:0] r_off   [plpl_pkg::REC_FIELDS];
    logic signed [31:0] r_q;
    logic               r_left;
    logic [AW-1:0]      r_lo;
    logic [AW-1:0]      r_hi;
    logic [AW-1:0]      r_mid;
    logic [AW-1:0]      r_raddr;
    logic               r_pside;
    logic [1:0]         r_cnt;
    plpl_pkg::t_w64     r_mul;
    plpl_pkg::t_w64     r_sdf;
    plpl_pkg::t_w64     r_sdl;
    plpl_pkg::t_w64     r_rel;
    plpl_pkg::t_w64     r_x0;
    plpl_pkg::t_w64     r_x1;
    plpl_pkg::t_w64     r_y0z;
    plpl_pkg::t_w64     r_y1z;
    plpl_pkg::t_w64     r_y0b;
    plpl_pkg::t_w64     r_y1b;
    plpl_pkg::t_w64     r_t;
    logic signed [31:0] r_z;
    logic signed [31:0] r_b;
    logic               r_app;
    logic               r_out_valid;
    plpl_pkg::t_out     r_out;

    logic               in_acc;
    logic               cfg_wr;
    logic [31:0]        idx32;
    logic [31:0]        pc32;
    logic [31:0]        n32;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [RW-1:0]      wdata;
    logic [RW-1:0]      rdata;
    logic [2:0]         fsel;
    logic [2:0]         zf;
    logic [2:0]         bf;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    plpl_pkg::t_w64     sc;
    plpl_pkg::t_w64     scv;
    plpl_pkg::t_w64     q64;
    plpl_pkg::t_w64     off0;
    plpl_pkg::t_w64     rel0;
    logic               cond_ok;
    plpl_pkg::t_w64     dx;
    plpl_pkg::t_w64     span;
    plpl_pkg::t_w64     dyz;
    plpl_pkg::t_w64     dyb;
    logic signed [XW-1:0] dxw;
    plpl_pkg::t_w64     num;
    plpl_pkg::t_seq_cmd cmd;
    plpl_pkg::t_seq_sts sts;
    plpl_pkg::t_w64     sa;
    plpl_pkg::t_w64     sb;
    plpl_pkg::t_w64     sres;
    plpl_pkg::t_w64     srem;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            plpl_pkg::REG_ENABLE: prdata = {31'd0, r_enable};
            plpl_pkg::REG_REPEAT: prdata = {31'd0, r_repeat};
            plpl_pkg::REG_COUNT:  prdata = {25'd0, r_point_count};
            default:              prdata = 32'd0;
        endcase
    end

    always_comb begin
        idx32 = 32'(i_in_data.point_index);
        waddr = idx32[AW-1:0];
        wdata = {i_in_data.point_bank_right, i_in_data.point_bank_left,
                 i_in_data.point_z_right, i_in_data.point_z_left, i_in_data.point_dist};
        we    = in_acc && (i_in_data.mode == plpl_pkg::MODE_POINT)
                && (idx32 < 32'(PROFILE_POINTS));
        pc32  = 32'(r_point_count);
        n32   = (pc32 > 32'(PROFILE_POINTS)) ? 32'(PROFILE_POINTS) : pc32;
    end

    plpl_ram #(
        .WIDTH (RW),
        .DEPTH (PROFILE_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        zf = r_left ? 3'd1 : 3'd2;
        bf = r_left ? 3'd3 : 3'd4;
        if (r_state == S_P_MUL || r_state == S_P_GET) begin
            case (r_cnt)
                2'd1:    fsel = zf;
                2'd2:    fsel = bf;
                default: fsel = 3'd0;
            endcase
        end else begin
            fsel = 3'd0;
        end
        ma   = $signed(rdata[32*fsel +: 32]);
        mb   = r_scale[fsel];
        sc   = r_mul >>> FRAC_BITS;
        scv  = sc + {{32{r_off[fsel][31]}}, r_off[fsel]};
        q64  = {{32{r_q[31]}}, r_q};
        off0 = {{32{r_off[0][31]}}, r_off[0]};
        rel0 = q64 - off0;
        cond_ok = (r_repeat || (q64 < r_sdl + off0)) && (q64 >= r_sdf + off0);
        dx   = r_rel - r_x0;
        span = r_x1 - r_x0;
        dyz  = r_y1z - r_y0z;
        dyb  = r_y1b - r_y0b;
        dxw  = XW'(dx) <<< FRAC_BITS;
        if (dxw > XW'(plpl_pkg::SAT_LIM)) begin
            num = plpl_pkg::SAT_LIM;
        end else if (dxw < -XW'(plpl_pkg::SAT_LIM)) begin
            num = -plpl_pkg::SAT_LIM;
        end else begin
            num = $signed(dxw[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= ma * mb;
    end

    always_comb begin
        cmd.start = 1'b0;
        cmd.op    = plpl_pkg::SEQ_DIV;
        sa        = rel0;
        sb        = r_sdl;
        unique case (r_state)
            S_CHECK: cmd.start = cond_ok && (r_sdl != 64'sd0);
            S_T: begin
                cmd.start = (span != 64'sd0);
                sa        = num;
                sb        = span;
            end
            S_MZ_GO: begin
                cmd.start = 1'b1;
                cmd.op    = plpl_pkg::SEQ_MUL;
                sa        = dyz;
                sb        = r_t;
            end
            S_MB_GO: begin
                cmd.start = 1'b1;
                cmd.op    = plpl_pkg::SEQ_MUL;
                sa        = dyb;
                sb        = r_t;
            end
            default: cmd.start = 1'b0;
        endcase
    end

    plpl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_a     (sa),
        .i_b     (sb),
        .o_sts   (sts),
        .o_res   (sres),
        .o_rem   (srem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_enable      <= 1'b0;
            r_repeat      <= 1'b1;
            r_point_count <= 7'd0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < plpl_pkg::REC_FIELDS; i++) begin
                r_scale[i] <= ONE;
                r_off[i]   <= 32'sd0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    plpl_pkg::REG_ENABLE: r_enable      <= pwdata[0];
                    plpl_pkg::REG_REPEAT: r_repeat      <= pwdata[0];
                    plpl_pkg::REG_COUNT:  r_point_count <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_data.mode)
                            plpl_pkg::MODE_SCALE: begin
                                r_scale[0] <= i_in_data.point_dist;
                                r_scale[1] <= i_in_data.point_z_left;
                                r_scale[2] <= i_in_data.point_z_right;
                                r_scale[3] <= i_in_data.point_bank_left;
                                r_scale[4] <= i_in_data.point_bank_right;
                            end
                            plpl_pkg::MODE_OFFSET: begin
                                r_off[0] <= i_in_data.point_dist;
                                r_off[1] <= i_in_data.point_z_left;
                                r_off[2] <= i_in_data.point_z_right;
                                r_off[3] <= i_in_data.point_bank_left;
                                r_off[4] <= i_in_data.point_bank_right;
                            end
                            plpl_pkg::MODE_QUERY: begin
                                r_q     <= i_in_data.query_distance;
                                r_left  <= i_in_data.lateral_offset[31];
                                r_lo    <= '0;
                                r_hi    <= AW'(n32 - 32'd1);
                                r_raddr <= '0;
                                r_z     <= 32'sd0;
                                r_b     <= 32'sd0;
                                r_app   <= 1'b0;
                                if (r_enable && n32 >= 32'd2) begin
                                    r_state <= S_F0_RD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_F0_RD:  r_state <= S_F0_MUL;
                S_F0_MUL: r_state <= S_F0_GET;
                S_F0_GET: begin
                    r_sdf   <= sc;
                    r_raddr <= r_hi;
                    r_state <= S_FL_RD;
                end
                S_FL_RD:  r_state <= S_FL_MUL;
                S_FL_MUL: r_state <= S_FL_GET;
                S_FL_GET: begin
                    r_sdl   <= sc;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_rel <= rel0;
                    if (!cond_ok) begin
                        r_state <= S_FIN;
                    end else if (r_sdl != 64'sd0) begin
                        r_state <= S_REM;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_REM: begin
                    if (sts.done) begin
                        r_rel   <= srem;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_hi - r_lo > AW'(1)) begin
                        r_mid   <= r_lo + ((r_hi - r_lo) >> 1);
                        r_raddr <= r_lo + ((r_hi - r_lo) >> 1);
                        r_state <= S_S_RD;
                    end else begin
                        r_raddr <= r_lo;
                        r_pside <= 1'b0;
                        r_cnt   <= 2'd0;
                        r_state <= S_P_RD;
                    end
                end
                S_S_RD:  r_state <= S_S_MUL;
                S_S_MUL: r_state <= S_S_CMP;
                S_S_CMP: begin
                    if (r_rel >= sc) begin
                        r_lo <= r_mid;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRCH;
                end
                S_P_RD:  r_state <= S_P_MUL;
                S_P_MUL: r_state <= S_P_GET;
                S_P_GET: begin
                    case ({r_pside, r_cnt})
                        3'b000:  r_x0  <= sc;
                        3'b001:  r_y0z <= scv;
                        3'b010:  r_y0b <= scv;
                        3'b100:  r_x1  <= sc;
                        3'b101:  r_y1z <= scv;
                        default: r_y1b <= scv;
                    endcase
                    if (r_cnt != 2'd2) begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_state <= S_P_MUL;
                    end else if (!r_pside) begin
                        r_pside <= 1'b1;
                        r_cnt   <= 2'd0;
                        r_raddr <= r_lo + AW'(1);
                        r_state <= S_P_RD;
                    end else begin
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    r_app <= 1'b1;
                    if (span == 64'sd0) begin
                        r_z     <= plpl_pkg::zero_span(r_y0z, dyz, dx);
                        r_b     <= plpl_pkg::zero_span(r_y0b, dyb, dx);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (sts.done) begin
                        r_t     <= sres;
                        r_state <= S_MZ_GO;
                    end
                end
                S_MZ_GO: r_state <= S_MZ;
                S_MZ: begin
                    if (sts.done) begin
                        r_z     <= plpl_pkg::sat32(r_y0z + (sres >>> FRAC_BITS));
                        r_state <= S_MB_GO;
                    end
                end
                S_MB_GO: r_state <= S_MB;
                S_MB: begin
                    if (sts.done) begin
                        r_b     <= plpl_pkg::sat32(r_y0b + (sres >>> FRAC_BITS));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.offset_z <= r_z;
                        r_out.banking  <= r_b;
                        r_out.applied  <= r_app;
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PLPL_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_acc && i_in_data.mode == plpl_pkg::MODE_QUERY, o_in_stall, "query not held")
    `PLPL_ASSERT_IMPL(a_zero_result, i_clk, i_rst_n, o_out_valid && !o_out_data.applied, o_out_data.offset_z == 32'sd0 && o_out_data.banking == 32'sd0, "nonzero unapplied result")
    `PLPL_ASSERT_IMPL(a_search_order, i_clk, i_rst_n, r_state == S_SRCH, r_lo < r_hi, "search bounds crossed")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NPTS = 64;
    localparam int FRAC = 16;
    localparam longint SAT = 64'sh4000_0000_0000_0000;
    localparam logic [3:0] ADDR_ENABLE = 4'd0;
    localparam logic [3:0] ADDR_REPEAT = 4'd4;
    localparam logic [3:0] ADDR_COUNT  = 4'd8;
    localparam int SETTLE = 400;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    logic           in_stall;
    plpl_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall;
    plpl_pkg::t_out out_data;
    logic           psel, penable, pwrite, pready;
    logic [3:0]     paddr;
    logic [31:0]    pwdata, prdata;

    piecewise_linear_profile_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    plpl_pkg::t_in  pend_q[$];
    plpl_pkg::t_out lookup_q[$];
    int   fail_cnt = 0;
    logic in_taken = 1'b0;
    logic no_idle = 1'b0;
    logic press_req = 1'b0;
    logic press_done = 1'b0;
    int   hold_cnt = 0;

    // profile image for prediction
    logic signed [31:0] p_dist[NPTS], p_zl[NPTS], p_zr[NPTS], p_bl[NPTS], p_br[NPTS];
    longint p_scale[5], p_off[5];
    logic   p_en, p_rep;
    logic [6:0] p_cnt;

    // stimulus-side copy of loaded distances
    int g_dist[NPTS];

    task automatic enqueue(plpl_pkg::t_in it);
        pend_q.insert(pend_q.size(), it);
    endtask

    function automatic longint fshift(longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint mul_clip(longint a, longint b);
        longint unsigned ua, ub, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ua == 0 || ub == 0) return 0;
        if (ub > longint'(SAT) / ua) return neg ? -SAT : SAT;
        p = ua * ub;
        if (p > SAT) p = SAT;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lerp(longint y0, longint y1, longint x0, longint x1,
                                    longint x);
        longint dy, dx, span, t;
        dy = y1 - y0;
        dx = x - x0;
        span = x1 - x0;
        if (span == 0) begin
            if (dy == 0 || dx == 0) return clip32(y0);
            return ((dy < 0) != (dx < 0)) ? -64'sd2147483648 : 64'sd2147483647;
        end
        t = mul_clip(dx, 64'sd1 << FRAC) / span;
        return clip32(y0 + fshift(mul_clip(dy, t)));
    endfunction

    function automatic longint sdist(int i);
        return fshift(longint'(p_dist[i]) * p_scale[0]);
    endfunction

    function automatic plpl_pkg::t_out lookup(plpl_pkg::t_in it);
        plpl_pkg::t_out r;
        longint q, rel, x0, x1, sd_first, sd_last, y0, y1, z, b;
        int n, lo, hi, mid;
        q = it.query_distance;
        z = 0;
        b = 0;
        r.applied = 1'b0;
        n = (p_cnt > NPTS) ? NPTS : p_cnt;
        if (p_en && n >= 2) begin
            sd_first = sdist(0);
            sd_last = sdist(n - 1);
            if ((p_rep || q < sd_last + p_off[0]) && q >= sd_first + p_off[0]) begin
                rel = q - p_off[0];
                if (sd_last != 0) rel = rel % sd_last;
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1) begin
                    mid = lo + (hi - lo) / 2;
                    if (rel >= sdist(mid)) lo = mid;
                    else hi = mid;
                end
                x0 = sdist(lo);
                x1 = sdist(lo + 1);
                if (it.lateral_offset < 0) begin
                    y0 = fshift(longint'(p_zl[lo]) * p_scale[1]) + p_off[1];
                    y1 = fshift(longint'(p_zl[lo+1]) * p_scale[1]) + p_off[1];
                    z = lerp(y0, y1, x0, x1, rel);
                    y0 = fshift(longint'(p_bl[lo]) * p_scale[3]) + p_off[3];
                    y1 = fshift(longint'(p_bl[lo+1]) * p_scale[3]) + p_off[3];
                    b = lerp(y0, y1, x0, x1, rel);
                end else begin
                    y0 = fshift(longint'(p_zr[lo]) * p_scale[2]) + p_off[2];
                    y1 = fshift(longint'(p_zr[lo+1]) * p_scale[2]) + p_off[2];
                    z = lerp(y0, y1, x0, x1, rel);
                    y0 = fshift(longint'(p_br[lo]) * p_scale[4]) + p_off[4];
                    y1 = fshift(longint'(p_br[lo+1]) * p_scale[4]) + p_off[4];
                    b = lerp(y0, y1, x0, x1, rel);
                end
                r.applied = 1'b1;
            end
        end
        r.offset_z = z[31:0];
        r.banking = b[31:0];
        return r;
    endfunction

    task automatic absorb(plpl_pkg::t_in it);
        case (it.mode)
            plpl_pkg::MODE_POINT: begin
                p_dist[it.point_index] = it.point_dist;
                p_zl[it.point_index] = it.point_z_left;
                p_zr[it.point_index] = it.point_z_right;
                p_bl[it.point_index] = it.point_bank_left;
                p_br[it.point_index] = it.point_bank_right;
            end
            plpl_pkg::MODE_SCALE: begin
                p_scale[0] = it.point_dist; p_scale[1] = it.point_z_left;
                p_scale[2] = it.point_z_right; p_scale[3] = it.point_bank_left;
                p_scale[4] = it.point_bank_right;
            end
            plpl_pkg::MODE_OFFSET: begin
                p_off[0] = it.point_dist; p_off[1] = it.point_z_left;
                p_off[2] = it.point_z_right; p_off[3] = it.point_bank_left;
                p_off[4] = it.point_bank_right;
            end
            default: lookup_q.insert(lookup_q.size(), lookup(it));
        endcase
    endtask

    // drive
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
                in_data <= pend_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= (hold_cnt != 0) || (!no_idle && $urandom_range(99) < 9);
    end

    // long receiver hold
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (press_req && !press_done) begin
            hold_cnt <= 3000;
            press_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        plpl_pkg::t_out e;
        in_taken <= i_rst_n && in_valid && !in_stall;
        if (i_rst_n) begin
            if (in_valid && !in_stall) absorb(in_data);
            if (out_valid && !out_stall) begin
                if (lookup_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected beat: %p", out_data);
                end else begin
                    e = lookup_q.pop_front();
                    if (e.offset_z !== out_data.offset_z || e.banking !== out_data.banking
                        || e.applied !== out_data.applied) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: exp z=%h b=%h a=%b got z=%h b=%h a=%b",
                                     e.offset_z, e.banking, e.applied, out_data.offset_z,
                                     out_data.banking, out_data.applied);
                    end
                end
            end
        end
    end

    task automatic apb_write(logic [3:0] a, logic [31:0] d);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic configure(logic en, logic rep, logic [6:0] cnt);
        apb_write(ADDR_ENABLE, {31'd0, en});
        apb_write(ADDR_REPEAT, {31'd0, rep});
        apb_write(ADDR_COUNT, {25'd0, cnt});
        p_en = en; p_rep = rep; p_cnt = cnt;
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_valid || lookup_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic plpl_pkg::t_in rec(plpl_pkg::t_mode m, logic [5:0] idx,
                                          logic [31:0] d, logic [31:0] a,
                                          logic [31:0] b2, logic [31:0] c, logic [31:0] e);
        plpl_pkg::t_in it;
        it.mode = m; it.point_index = idx; it.point_dist = d; it.point_z_left = a;
        it.point_z_right = b2; it.point_bank_left = c; it.point_bank_right = e;
        it.query_distance = $urandom; it.lateral_offset = $urandom;
        return it;
    endfunction

    function automatic plpl_pkg::t_in ask(int q, int lat);
        plpl_pkg::t_in it;
        it = rec(plpl_pkg::MODE_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                 $urandom, $urandom);
        it.query_distance = q;
        it.lateral_offset = lat;
        return it;
    endfunction

    task automatic load_profile(bit dups);
        int d;
        d = int'($urandom_range(200000)) - 100000;
        for (int i = 0; i < NPTS; i++) begin
            if (i != 0) d += (dups && $urandom_range(9) == 0) ? 0 : $urandom_range(1 << 18);
            g_dist[i] = d;
            enqueue(rec(plpl_pkg::MODE_POINT, 6'(i), d, $urandom, $urandom, $urandom,
                        $urandom));
        end
    endtask

    function automatic int near_query(int n);
        int lo, span;
        lo = g_dist[0];
        span = g_dist[(n < 2) ? 1 : n - 1] - lo + 1;
        return lo - span / 8 + int'($urandom_range(span + span / 4));
    endfunction

    function automatic plpl_pkg::t_in random_item(int n);
        plpl_pkg::t_in it;
        int r, k;
        r = $urandom_range(99);
        if (r < 70) begin
            it = ask(($urandom_range(9) == 0) ? $urandom : near_query(n), $urandom);
        end else if (r < 90) begin
            k = $urandom_range(NPTS - 1);
            if ($urandom_range(9) == 0) g_dist[k] = $urandom;
            it = rec(plpl_pkg::MODE_POINT, 6'(k), g_dist[k], $urandom, $urandom, $urandom,
                     $urandom);
        end else if (r < 95) begin
            it = rec(plpl_pkg::MODE_SCALE, 6'($urandom),
                     ($urandom_range(4) == 0) ? $urandom_range(32'h8000, 32'h18000) : 65536,
                     $urandom_range(32'h20000), $urandom_range(32'h20000),
                     ($urandom_range(9) == 0) ? $urandom : 65536, 32'hffff_0000);
        end else begin
            it = rec(plpl_pkg::MODE_OFFSET, 6'($urandom),
                     int'($urandom_range(1 << 16)) - (1 << 15), $urandom, $urandom,
                     int'($urandom_range(1 << 20)) - (1 << 19), $urandom);
        end
        return it;
    endfunction

    initial begin
        logic [6:0] cnt;
        int n;
        in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < 5; i++) begin
            p_scale[i] = 65536; p_off[i] = 0;
        end
        p_en = 1'b0; p_rep = 1'b1; p_cnt = 7'd0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // disabled profile, then full load
        enqueue(ask(0, -1));
        load_profile(1'b1);
        drain();
        configure(1'b1, 1'b0, 7'd64);
        enqueue(ask(g_dist[0] - 1, 5));
        enqueue(ask(g_dist[0], -5));
        enqueue(ask((g_dist[0] + g_dist[63]) / 2, 32'h7fff_ffff));
        enqueue(ask(g_dist[63], 32'h8000_0000));
        enqueue(ask(32'h7fff_ffff, 0));
        enqueue(ask(32'h8000_0000, -1));
        enqueue(rec(plpl_pkg::MODE_SCALE, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff));
        enqueue(rec(plpl_pkg::MODE_OFFSET, 6'd0, 0, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000));
        enqueue(ask(g_dist[0] + 100, -7));
        enqueue(ask(g_dist[0] + 100, 7));
        // zero distance scale: no period, every span empty
        enqueue(rec(plpl_pkg::MODE_SCALE, 6'd0, 0, 65536, 65536, 65536, 65536));
        enqueue(rec(plpl_pkg::MODE_OFFSET, 6'd0, 0, 0, 0, 0, 0));
        enqueue(ask(0, 1));
        enqueue(ask(12345, -1));
        enqueue(ask(-1, 1));
        enqueue(rec(plpl_pkg::MODE_SCALE, 6'd0, 65536, 65536, 65536, 65536, 65536));
        drain();
        configure(1'b1, 1'b1, 7'd127);
        enqueue(ask(g_dist[63] * 2 + 3, -1));
        enqueue(ask(g_dist[63], 1));
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: cnt = 7'd2;
                1: cnt = 7'd0;
                2: cnt = 7'd1;
                3: cnt = 7'd127;
                4: cnt = 7'd3;
                default: cnt = (ph % 2) ? 7'd64 : 7'($urandom_range(2, 64));
            endcase
            configure((ph == 1) ? 1'b1 : (ph == 5 ? 1'b0 : 1'b1), ph[0], cnt);
            n = (cnt > NPTS) ? NPTS : cnt;
            no_idle = (ph == 7);
            if (ph == 2 || ph == 9) load_profile(ph == 9);
            press_req = (ph == 4);
            for (int i = 0; i < 100; i++) enqueue(random_item(n));
            drain();
        end
        press_req = 1'b0;
        drain();
        if (fail_cnt == 0 && lookup_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/plpl_pkg.sv
design/plpl_ram.sv
design/plpl_seq.sv
design/piecewise_linear_profile_lookup.sv
tb/tb_top.sv
